// ----- hdl/best_first_move_picker_macros.svh -----
`ifndef BEST_FIRST_MOVE_PICKER_MACROS_SVH
`define BEST_FIRST_MOVE_PICKER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define BFMP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("best_first_move_picker check failed");

// next-cycle implication, checked while out of reset
`define BFMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("best_first_move_picker check failed");

`endif

// ----- hdl/bfmp_pkg.sv -----
`default_nettype none

package bfmp_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int MOVE_W = 32;
  localparam int SCORE_W = 32;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_NEXT   = 2'd2;

  typedef struct packed {
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic                      cap;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic scan_init;
    logic res_none;
    logic scan;
    logic wr_best;
    logic wr_cur;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic conly;
    logic last;
    logic hit;
  } stat_t;

endpackage

`default_nettype wire

// ----- hdl/bfmp_ctrl.sv -----
`default_nettype none

module bfmp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      func,
  input  bfmp_pkg::stat_t stat,
  output logic            busy,
  output logic            done,
  output bfmp_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SWAP_BEST,
    S_SWAP_CUR
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (func)
            bfmp_pkg::FUNC_CLEAR:  cmd.clear = 1'b1;
            bfmp_pkg::FUNC_APPEND: cmd.append = 1'b1;
            bfmp_pkg::FUNC_NEXT: begin
              if (stat.empty) begin
                cmd.res_none = 1'b1;
              end else begin
                cmd.scan_init = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN:      cmd.scan = 1'b1;
      S_SWAP_BEST: cmd.wr_best = 1'b1;
      S_SWAP_CUR:  cmd.wr_cur = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && func == bfmp_pkg::FUNC_NEXT) begin
            if (stat.empty) begin
              done <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (stat.conly) begin
            if (stat.hit || stat.last) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else if (stat.last) begin
            state <= S_SWAP_BEST;
          end
        end
        S_SWAP_BEST: state <= S_SWAP_CUR;
        S_SWAP_CUR: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bfmp_dp.sv -----
`default_nettype none

module bfmp_dp #(
  parameter int MAX_ENTRIES = bfmp_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bfmp_pkg::cmd_t                       cmd,
  input  logic [bfmp_pkg::MOVE_W-1:0]          move_word,
  input  logic signed [bfmp_pkg::SCORE_W-1:0]  move_score,
  input  logic                                 is_capture,
  input  logic                                 captures_only,
  output bfmp_pkg::stat_t                      stat,
  output logic [bfmp_pkg::MOVE_W-1:0]          move_out,
  output logic                                 found,
  output logic                                 more_left
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  bfmp_pkg::entry_t mem [MAX_ENTRIES];
  bfmp_pkg::entry_t rdata;
  bfmp_pkg::entry_t best;
  bfmp_pkg::entry_t cur_ent;
  bfmp_pkg::entry_t wdata;

  logic [CW-1:0] cnt;
  logic [CW-1:0] cur;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] ev_idx;
  logic [CW-1:0] ev_inc;
  logic [CW-1:0] cur_inc;
  logic [IW-1:0] best_idx;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;
  logic          mode;
  logic          we;
  logic          not_full;
  logic          first;

  assign ev_inc   = ev_idx + CW'(1);
  assign cur_inc  = cur + CW'(1);
  assign not_full = (cnt < CW'(MAX_ENTRIES));
  assign first    = (ev_idx == cur);
  assign raddr    = cmd.scan ? rd_idx[IW-1:0] : cur[IW-1:0];

  assign stat.empty = (cur >= cnt);
  assign stat.conly = mode;
  assign stat.last  = (ev_inc == cnt);
  assign stat.hit   = rdata.cap;

  // single write port shared by append, capture-scan zeroing and the swap
  always_comb begin
    we    = 1'b0;
    waddr = cnt[IW-1:0];
    wdata = '{move: move_word, score: move_score, cap: is_capture};
    if (cmd.append && not_full) begin
      we = 1'b1;
    end else if (cmd.scan && mode) begin
      we    = 1'b1;
      waddr = ev_idx[IW-1:0];
      wdata = '{move: rdata.move, score: '0, cap: rdata.cap};
    end else if (cmd.wr_best) begin
      we    = 1'b1;
      waddr = best_idx;
      wdata = cur_ent;
    end else if (cmd.wr_cur) begin
      we    = 1'b1;
      waddr = cur[IW-1:0];
      wdata = '{move: best.move, score: '0, cap: best.cap};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      cur <= '0;
    end else begin
      if (cmd.clear) begin
        cnt <= '0;
        cur <= '0;
      end
      if (cmd.append && not_full) begin
        cnt <= cnt + CW'(1);
      end
      if (cmd.scan && mode && rdata.cap) begin
        cur <= ev_inc;
      end
      if (cmd.wr_cur) begin
        cur <= cur_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      mode   <= captures_only;
      rd_idx <= cur_inc;
      ev_idx <= cur;
    end
    if (cmd.scan) begin
      rd_idx <= rd_idx + CW'(1);
      ev_idx <= ev_inc;
      if (!mode && (first || rdata.score > best.score)) begin
        best     <= rdata;
        best_idx <= ev_idx[IW-1:0];
      end
      if (!mode && first) begin
        cur_ent <= rdata;
      end
    end

    if (cmd.res_none) begin
      move_out  <= '0;
      found     <= 1'b0;
      more_left <= 1'b0;
    end else if (cmd.scan && mode && rdata.cap) begin
      move_out  <= rdata.move;
      found     <= 1'b1;
      more_left <= (ev_inc < cnt);
    end else if (cmd.scan && mode && stat.last) begin
      move_out  <= '0;
      found     <= 1'b0;
      more_left <= 1'b1;
    end else if (cmd.wr_cur) begin
      move_out  <= best.move;
      found     <= 1'b1;
      more_left <= (cur_inc < cnt);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/best_first_move_picker.sv -----
// clear and append give no result; next on an exhausted list: done in the next cycle
// captures-only: the scan stops at the first capture or at the last entry
// next in normal mode: scans the entries from cursor to end, one entry per
// cycle through the single read port of the entry memory, then two swap writes
// synchronous rst clears count and cursor; the entry memory is left as is
// result held one cycle with done, next item taken in that cycle; receiver cannot stall
`default_nettype none

module best_first_move_picker #(
  parameter int MAX_ENTRIES = bfmp_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [1:0]                           func,
  input  logic [bfmp_pkg::MOVE_W-1:0]          move_word,
  input  logic signed [bfmp_pkg::SCORE_W-1:0]  move_score,
  input  logic                                 is_capture,
  input  logic                                 captures_only,
  output logic                                 busy,
  output logic                                 done,
  output logic [bfmp_pkg::MOVE_W-1:0]          move_out,
  output logic                                 found,
  output logic                                 more_left
);

  bfmp_pkg::cmd_t  cmd;
  bfmp_pkg::stat_t stat;

  bfmp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  bfmp_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .move_word     (move_word),
    .move_score    (move_score),
    .is_capture    (is_capture),
    .captures_only (captures_only),
    .stat          (stat),
    .move_out      (move_out),
    .found         (found),
    .more_left     (more_left)
  );

endmodule

`default_nettype wire

// ----- hdl/bfmp_checker.sv -----
`default_nettype none

`include "best_first_move_picker_macros.svh"

module bfmp_assertions (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                start,
  input wire logic [1:0]                          func,
  input wire logic                                busy,
  input wire logic                                done,
  input wire logic [bfmp_pkg::MOVE_W-1:0]         move_out,
  input wire logic                                found
);

  // a miss returns a zero move
  `BFMP_ASSERT_SAME(a_miss_zero, done && !found, move_out == '0)

  // every result follows an accepted item or a busy cycle
  `BFMP_ASSERT_SAME(a_done_cause, done, $past(busy) || $past(start))

  // a returned move always comes out of a scan
  `BFMP_ASSERT_SAME(a_found_scanned, done && found, $past(busy))

  // clear, append and unused codes give no result
  `BFMP_ASSERT_NEXT(a_no_result, start && !busy && func != bfmp_pkg::FUNC_NEXT, !done)

endmodule

bind best_first_move_picker bfmp_assertions u_bfmp_assertions (.*);

`default_nettype wire
